@@ hdl/avc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avc_pkg: arrowhead vertex calculator definitions
// Widths, register indexes, reset values, the CORDIC arctangent table and
// the final truncate-and-saturate helper.
// ----------------------------------------------------------------------------
package avc_pkg;

	localparam int COORD_BITS    = 16;
	localparam int ANGLE_BITS    = 16;
	localparam int CORDIC_STAGES = 16;

	// Configuration port
	localparam int CFG_W     = 16;
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_BARB_LENGTH = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_BARB_ANGLE  = 1'd1;
	localparam logic [CFG_W-1:0] BARB_LENGTH_RST = 16'd2560;
	localparam logic [CFG_W-1:0] BARB_ANGLE_RST  = 16'd5461;

	// Fixed-point layout
	localparam int VGUARD = 16;                       // guard bits of the vectoring CORDIC
	localparam int RFRAC  = 24;                       // fraction bits of the rotation CORDIC
	localparam int KX_W   = 32;                       // scaled barb length, pixels Q.24
	localparam int PROD_W = CFG_W + 32;
	localparam logic [PROD_W-1:0] KINV_Q32 = PROD_W'(32'h9B74EDA8);
	localparam int DW = COORD_BITS + 1;               // coordinate difference
	localparam int VW = COORD_BITS + VGUARD + 4;      // vectoring x/y
	localparam int RW = RFRAC + 11;                   // rotation x/y
	localparam int SW = COORD_BITS + RFRAC + 2;       // tail plus offset
	localparam int QW = SW - RFRAC;                   // integer part of that sum

	localparam logic [ANGLE_BITS-1:0] AHALF = {1'b1, {(ANGLE_BITS-1){1'b0}}};

	// Cycles from the accepting edge to the edge that takes the result.
	localparam int LATENCY = 2 * CORDIC_STAGES + 5;

	// atan(2^-i), 2^31 = pi
	localparam int ATAN_N     = 24;
	localparam int ATAN_IDX_W = 5;
	localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Table entry rounded half up to ANGLE_BITS.
	function automatic logic [ANGLE_BITS-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
		logic [32:0] t;
		t = {1'b0, ATAN_TAB[idx]} + (33'd1 << (31 - ANGLE_BITS));
		return t[31:32-ANGLE_BITS];
	endfunction

	// Drop RFRAC fraction bits toward zero, then clamp to the coordinate range.
	function automatic logic signed [COORD_BITS-1:0] trunc_sat(input logic signed [SW-1:0] s);
		logic signed [SW-1:0] adj;
		logic signed [QW-1:0] q;
		logic signed [QW-1:0] q_hi;
		logic signed [QW-1:0] q_lo;
		q_hi = QW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
		q_lo = -q_hi - QW'(1);
		adj = s + (s[SW-1] ? SW'((64'd1 << RFRAC) - 64'd1) : SW'(0));
		q = QW'(adj >>> RFRAC);
		if (q > q_hi) begin
			return q_hi[COORD_BITS-1:0];
		end else if (q < q_lo) begin
			return q_lo[COORD_BITS-1:0];
		end
		return q[COORD_BITS-1:0];
	endfunction

endpackage

@@ hdl/arrowhead_vertex_calc.sv @@
`timescale 1ns / 1ps
// Each accepted item passes the input stage, both CORDIC pipelines and the sum and output
// registers; its result is then on the outputs, with done high, for a single cycle.
// Throughput: one item per clock; busy is always low and every item passes through
// the two 16-stage unrolled CORDIC pipelines.
// Results are not held: the receiver takes each one in its done cycle.
// Reset clears all valid bits and done, and loads barb_length = 2560, barb_angle = 5461.
// ----------------------------------------------------------------------------
// arrowhead_vertex_calc
// Barb vertices of an arrow head: a vectoring CORDIC finds the arrow direction,
// two rotation CORDIC lanes turn the scaled barb length by +/- the half angle.
// ----------------------------------------------------------------------------
module arrowhead_vertex_calc (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [avc_pkg::COORD_BITS-1:0]  head_x,
	input  logic signed [avc_pkg::COORD_BITS-1:0]  head_y,
	input  logic signed [avc_pkg::COORD_BITS-1:0]  tail_x,
	input  logic signed [avc_pkg::COORD_BITS-1:0]  tail_y,
	output logic                                   done,
	output logic signed [avc_pkg::COORD_BITS-1:0]  left_x,
	output logic signed [avc_pkg::COORD_BITS-1:0]  left_y,
	output logic signed [avc_pkg::COORD_BITS-1:0]  right_x,
	output logic signed [avc_pkg::COORD_BITS-1:0]  right_y,
	input  logic                                   cfg_we,
	input  logic [avc_pkg::REG_IDX_W-1:0]          cfg_index,
	input  logic [avc_pkg::CFG_W-1:0]              cfg_data
);

	localparam int C  = avc_pkg::COORD_BITS;
	localparam int A  = avc_pkg::ANGLE_BITS;
	localparam int N  = avc_pkg::CORDIC_STAGES;
	localparam int DW = avc_pkg::DW;
	localparam int VW = avc_pkg::VW;
	localparam int RW = avc_pkg::RW;
	localparam int SW = avc_pkg::SW;

	// ------------------------------------------------------------------
	// Configuration registers and the gain-compensated barb length
	// ------------------------------------------------------------------
	logic [avc_pkg::CFG_W-1:0]  barb_length_q;
	logic [avc_pkg::CFG_W-1:0]  barb_angle_q;
	logic [avc_pkg::KX_W-1:0]   kx_q;
	logic [avc_pkg::PROD_W-1:0] kprod;
	logic [A-1:0]               barb_a;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			barb_length_q <= avc_pkg::BARB_LENGTH_RST;
			barb_angle_q  <= avc_pkg::BARB_ANGLE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				avc_pkg::REG_BARB_LENGTH: barb_length_q <= cfg_data;
				avc_pkg::REG_BARB_ANGLE:  barb_angle_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign kprod = avc_pkg::PROD_W'(barb_length_q) * avc_pkg::KINV_Q32;

	always_ff @(posedge clk) begin
		kx_q <= kprod[avc_pkg::PROD_W-1:16];
	end

	generate
		if (A >= avc_pkg::CFG_W) begin : g_barb_wide
			assign barb_a = A'(barb_angle_q) << (A - avc_pkg::CFG_W);
		end else begin : g_barb_narrow
			assign barb_a = A'(barb_angle_q >> (avc_pkg::CFG_W - A));
		end
	endgenerate

	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// Input stage: difference from head to tail
	// ------------------------------------------------------------------
	logic                 in_v_s1;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic signed [C-1:0]  tx_s1, ty_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else begin
			in_v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			dx_s1 <= DW'(tail_x) - DW'(head_x);
			dy_s1 <= DW'(tail_y) - DW'(head_y);
			tx_s1 <= tail_x;
			ty_s1 <= tail_y;
		end
	end

	// ------------------------------------------------------------------
	// Vectoring CORDIC: angle of (dx, dy)
	// ------------------------------------------------------------------
	logic                 vv_s    [N+1];
	logic signed [VW-1:0] vx_s    [N+1];
	logic signed [VW-1:0] vy_s    [N+1];
	logic [A-1:0]         vz_s    [N+1];
	logic                 vzero_s [N+1];
	logic signed [C-1:0]  vtx_s   [N+1];
	logic signed [C-1:0]  vty_s   [N+1];

	logic                 dneg;
	logic signed [DW-1:0] dxa, dya;

	// Left half plane: negate and start from pi.
	assign dneg = dx_s1[DW-1];
	assign dxa  = dneg ? -dx_s1 : dx_s1;
	assign dya  = dneg ? -dy_s1 : dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vv_s[0] <= 1'b0;
		end else begin
			vv_s[0] <= in_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_v_s1) begin
			vx_s[0]    <= VW'(dxa) <<< avc_pkg::VGUARD;
			vy_s[0]    <= VW'(dya) <<< avc_pkg::VGUARD;
			vz_s[0]    <= dneg ? avc_pkg::AHALF : A'(0);
			vzero_s[0] <= (dx_s1 == DW'(0)) && (dy_s1 == DW'(0));
			vtx_s[0]   <= tx_s1;
			vty_s[0]   <= ty_s1;
		end
	end

	generate
		for (genvar i = 0; i < N; i++) begin : g_vec
			localparam logic [A-1:0] ATN = avc_pkg::atan_entry(avc_pkg::ATAN_IDX_W'(i));
			logic signed [VW-1:0] xsh, ysh;

			assign xsh = vx_s[i] >>> i;
			assign ysh = vy_s[i] >>> i;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vv_s[i+1] <= 1'b0;
				end else begin
					vv_s[i+1] <= vv_s[i];
				end
			end

			always_ff @(posedge clk) begin
				if (vv_s[i]) begin
					if (!vy_s[i][VW-1]) begin
						vx_s[i+1] <= vx_s[i] + ysh;
						vy_s[i+1] <= vy_s[i] - xsh;
						vz_s[i+1] <= vz_s[i] + ATN;
					end else begin
						vx_s[i+1] <= vx_s[i] - ysh;
						vy_s[i+1] <= vy_s[i] + xsh;
						vz_s[i+1] <= vz_s[i] - ATN;
					end
					vzero_s[i+1] <= vzero_s[i];
					vtx_s[i+1]   <= vtx_s[i];
					vty_s[i+1]   <= vty_s[i];
				end
			end
		end
	endgenerate

	// ------------------------------------------------------------------
	// Barb angles and quadrant folding
	// ------------------------------------------------------------------
	logic [A-1:0] base_a, al_a, ar_a;
	logic         nl, nr;

	// A zero-length arrow has no direction: its base angle is pi.
	assign base_a = vzero_s[N] ? avc_pkg::AHALF : vz_s[N] + avc_pkg::AHALF;
	assign al_a   = base_a - barb_a;
	assign ar_a   = base_a + barb_a;
	assign nl     = al_a[A-1] ^ al_a[A-2];
	assign nr     = ar_a[A-1] ^ ar_a[A-2];

	logic                 rv_s  [N+1];
	logic signed [RW-1:0] rlx_s [N+1];
	logic signed [RW-1:0] rly_s [N+1];
	logic signed [A-1:0]  rzl_s [N+1];
	logic                 rnl_s [N+1];
	logic signed [RW-1:0] rrx_s [N+1];
	logic signed [RW-1:0] rry_s [N+1];
	logic signed [A-1:0]  rzr_s [N+1];
	logic                 rnr_s [N+1];
	logic signed [C-1:0]  rtx_s [N+1];
	logic signed [C-1:0]  rty_s [N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s[0] <= 1'b0;
		end else begin
			rv_s[0] <= vv_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (vv_s[N]) begin
			rlx_s[0] <= RW'(kx_q);
			rly_s[0] <= RW'(0);
			rzl_s[0] <= nl ? (al_a ^ avc_pkg::AHALF) : al_a;
			rnl_s[0] <= nl;
			rrx_s[0] <= RW'(kx_q);
			rry_s[0] <= RW'(0);
			rzr_s[0] <= nr ? (ar_a ^ avc_pkg::AHALF) : ar_a;
			rnr_s[0] <= nr;
			rtx_s[0] <= vtx_s[N];
			rty_s[0] <= vty_s[N];
		end
	end

	// ------------------------------------------------------------------
	// Rotation CORDIC, left and right lanes side by side
	// ------------------------------------------------------------------
	generate
		for (genvar i = 0; i < N; i++) begin : g_rot
			localparam logic signed [A-1:0] ATN =
				A'(avc_pkg::atan_entry(avc_pkg::ATAN_IDX_W'(i)));
			logic signed [RW-1:0] lxsh, lysh, rxsh, rysh;

			assign lxsh = rlx_s[i] >>> i;
			assign lysh = rly_s[i] >>> i;
			assign rxsh = rrx_s[i] >>> i;
			assign rysh = rry_s[i] >>> i;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					rv_s[i+1] <= 1'b0;
				end else begin
					rv_s[i+1] <= rv_s[i];
				end
			end

			always_ff @(posedge clk) begin
				if (rv_s[i]) begin
					if (!rzl_s[i][A-1]) begin
						rlx_s[i+1] <= rlx_s[i] - lysh;
						rly_s[i+1] <= rly_s[i] + lxsh;
						rzl_s[i+1] <= rzl_s[i] - ATN;
					end else begin
						rlx_s[i+1] <= rlx_s[i] + lysh;
						rly_s[i+1] <= rly_s[i] - lxsh;
						rzl_s[i+1] <= rzl_s[i] + ATN;
					end
					if (!rzr_s[i][A-1]) begin
						rrx_s[i+1] <= rrx_s[i] - rysh;
						rry_s[i+1] <= rry_s[i] + rxsh;
						rzr_s[i+1] <= rzr_s[i] - ATN;
					end else begin
						rrx_s[i+1] <= rrx_s[i] + rysh;
						rry_s[i+1] <= rry_s[i] - rxsh;
						rzr_s[i+1] <= rzr_s[i] + ATN;
					end
					rnl_s[i+1] <= rnl_s[i];
					rnr_s[i+1] <= rnr_s[i];
					rtx_s[i+1] <= rtx_s[i];
					rty_s[i+1] <= rty_s[i];
				end
			end
		end
	endgenerate

	// ------------------------------------------------------------------
	// Add to the tail point (folded lanes subtract), then truncate and clamp
	// ------------------------------------------------------------------
	logic                 fin_v_s;
	logic signed [SW-1:0] fin_lx_s, fin_ly_s, fin_rx_s, fin_ry_s;
	logic signed [SW-1:0] tx_ext, ty_ext;

	assign tx_ext = SW'(rtx_s[N]) <<< avc_pkg::RFRAC;
	assign ty_ext = SW'(rty_s[N]) <<< avc_pkg::RFRAC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s <= 1'b0;
		end else begin
			fin_v_s <= rv_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (rv_s[N]) begin
			fin_lx_s <= rnl_s[N] ? tx_ext - SW'(rlx_s[N]) : tx_ext + SW'(rlx_s[N]);
			fin_ly_s <= rnl_s[N] ? ty_ext - SW'(rly_s[N]) : ty_ext + SW'(rly_s[N]);
			fin_rx_s <= rnr_s[N] ? tx_ext - SW'(rrx_s[N]) : tx_ext + SW'(rrx_s[N]);
			fin_ry_s <= rnr_s[N] ? ty_ext - SW'(rry_s[N]) : ty_ext + SW'(rry_s[N]);
		end
	end

	logic                done_q;
	logic signed [C-1:0] lx_q, ly_q, rx_q, ry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_v_s) begin
			lx_q <= avc_pkg::trunc_sat(fin_lx_s);
			ly_q <= avc_pkg::trunc_sat(fin_ly_s);
			rx_q <= avc_pkg::trunc_sat(fin_rx_s);
			ry_q <= avc_pkg::trunc_sat(fin_ry_s);
		end
	end

	assign done    = done_q;
	assign left_x  = lx_q;
	assign left_y  = ly_q;
	assign right_x = rx_q;
	assign right_y = ry_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(avc_pkg::LATENCY) done)
		else $error("accepted item did not produce a result on time");

	a_no_spurious : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, avc_pkg::LATENCY))
		else $error("result without a matching accepted item");

	a_lanes_match : assert property (@(posedge clk) disable iff (!arst_n)
		(rv_s[0] && rzl_s[0] == rzr_s[0] && rnl_s[0] == rnr_s[0])
		|-> ##(N + 1) (fin_lx_s == fin_rx_s && fin_ly_s == fin_ry_s))
		else $error("rotation lanes disagree for equal barb angles");

endmodule
